>>> hdl/tws_pkg.sv
`timescale 1ns / 1ps

package tws_pkg;

    // Sequencer phase codes; codes 26 to 31 are unused and fall back to idle
    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_RST_REL   = 5'd1,
        PH_RST_HI    = 5'd2,
        PH_RST_LO    = 5'd3,
        PH_ST1       = 5'd4,
        PH_ST2       = 5'd5,
        PH_ST3       = 5'd6,
        PH_ST4       = 5'd7,
        PH_ST5       = 5'd8,
        PH_ST6       = 5'd9,
        PH_TX_LO     = 5'd10,
        PH_TX_DATA   = 5'd11,
        PH_TX_HI     = 5'd12,
        PH_TX_ENDLO  = 5'd13,
        PH_TX_REL    = 5'd14,
        PH_TX_ACKHI  = 5'd15,
        PH_TX_ACKSMP = 5'd16,
        PH_POLL      = 5'd17,
        PH_RX_HI     = 5'd18,
        PH_RX_LO     = 5'd19,
        PH_RXA_PULL  = 5'd20,
        PH_RXA_HI    = 5'd21,
        PH_RXA_LO    = 5'd22,
        PH_RXA_REL   = 5'd23,
        PH_RXN_HI    = 5'd24,
        PH_RXN_LO    = 5'd25
    } t_phase;

    // Command codes
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_MEASURE = 2'd1;
    localparam logic [1:0] CMD_RESET   = 2'd2;

    // Completion status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_ACK  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_CRC_ERR = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_STATUS_NIBBLE = 2'd0;
    localparam logic [1:0] REG_POLL_INTERVAL = 2'd1;
    localparam logic [1:0] REG_MAX_POLLS     = 2'd2;

    // Register reset values
    localparam logic [3:0]  STATUS_NIBBLE_RST = 4'd0;
    localparam logic [15:0] POLL_INTERVAL_RST = 16'd100;
    localparam logic [7:0]  MAX_POLLS_RST     = 8'd62;

    localparam logic [7:0] CRC_POLY      = 8'h31;
    localparam logic [3:0] RST_PULSES    = 4'd9;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [7:0] ACKED_BYTES   = 8'd2;

    typedef struct packed {
        t_phase       phase;
        logic [3:0]   bit_count;
        logic [7:0]   shift_byte;
        logic [7:0]   crc;
        logic [15:0]  value;
        logic [7:0]   poll_count;
        logic [15:0]  wait_count;
        logic         is_reset_op;
        logic         drv_sck;
        logic         drv_pull;
    } t_state;

    typedef struct packed {
        logic [3:0]  status_nibble;
        logic [15:0] poll_interval;
        logic [7:0]  max_polls;
    } t_cfg;

    typedef struct packed {
        logic        sck_level;
        logic        data_pull_low;
        logic        busy_res;
        logic        done_res;
        logic [15:0] measured_value;
        logic [1:0]  status;
    } t_result;

    // Reverse the bit order of a byte
    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7 - k] = v[k];
        end
        return r;
    endfunction

    // Fold one byte into the CRC-8, MSB first
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       top;
        c = crc_in;
        d = data;
        for (int k = 0; k < 8; k++) begin
            top = c[7] ^ d[7];
            c   = {c[6:0], 1'b0};
            if (top) begin
                c = c ^ CRC_POLY;
            end
            d = {d[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> hdl/tws_if.sv
`timescale 1ns / 1ps

// Tick channel into the master
interface tws_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] command_byte;
    logic       data_level;

    modport source (output valid, cmd, command_byte, data_level, input ready);
    modport sink   (input valid, cmd, command_byte, data_level, output ready);
endinterface

// Per-tick result channel out of the master
interface tws_out_if;
    logic        valid;
    logic        ready;
    logic        sck_level;
    logic        data_pull_low;
    logic        busy_res;
    logic        done_res;
    logic [15:0] measured_value;
    logic [1:0]  status;

    modport source (output valid, sck_level, data_pull_low, busy_res, done_res,
                    measured_value, status, input ready);
    modport sink   (input valid, sck_level, data_pull_low, busy_res, done_res,
                    measured_value, status, output ready);
endinterface

// Configuration register write channel
interface tws_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/tws_step.sv
`timescale 1ns / 1ps

module tws_step
    import tws_pkg::*;
(
    input  t_state     i_state,
    input  t_cfg       i_cfg,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_command_byte,
    input  logic       i_data_level,
    output t_state     o_state,
    output t_result    o_result
);

    t_state     s;
    logic       done;
    logic [1:0] st;
    logic [15:0] val;

    always_comb begin
        s    = i_state;
        done = 1'b0;
        st   = ST_OK;
        val  = '0;

        // Latch a new command while idle
        if (s.phase == PH_IDLE && (i_cmd == CMD_MEASURE || i_cmd == CMD_RESET)) begin
            s.shift_byte  = i_command_byte;
            s.is_reset_op = (i_cmd == CMD_RESET);
            s.value       = '0;
            s.bit_count   = '0;
            s.poll_count  = '0;
            s.wait_count  = '0;
            s.phase       = (i_cmd == CMD_RESET) ? PH_RST_REL : PH_ST1;
        end

        // Advance one half-bit tick
        unique case (s.phase)
            PH_IDLE: begin
            end
            PH_RST_REL: begin
                s.drv_sck   = 1'b0;
                s.drv_pull  = 1'b0;
                s.bit_count = '0;
                s.phase     = PH_RST_HI;
            end
            PH_RST_HI: begin
                s.drv_sck = 1'b1;
                s.phase   = PH_RST_LO;
            end
            PH_RST_LO: begin
                s.drv_sck   = 1'b0;
                s.bit_count = s.bit_count + 4'd1;
                s.phase     = (s.bit_count >= RST_PULSES) ? PH_ST1 : PH_RST_HI;
            end
            PH_ST1: begin
                s.drv_sck  = 1'b1;
                s.drv_pull = 1'b0;
                s.phase    = PH_ST2;
            end
            PH_ST2: begin
                s.drv_pull = 1'b1;
                s.phase    = PH_ST3;
            end
            PH_ST3: begin
                s.drv_sck = 1'b0;
                s.phase   = PH_ST4;
            end
            PH_ST4: begin
                s.drv_sck = 1'b1;
                s.phase   = PH_ST5;
            end
            PH_ST5: begin
                s.drv_pull = 1'b0;
                s.phase    = PH_ST6;
            end
            PH_ST6: begin
                s.drv_sck   = 1'b0;
                s.crc       = mirror8({4'd0, i_cfg.status_nibble});
                s.bit_count = '0;
                s.phase     = PH_TX_LO;
            end
            PH_TX_LO: begin
                s.drv_sck = 1'b0;
                s.phase   = PH_TX_DATA;
            end
            PH_TX_DATA: begin
                s.drv_pull = ~s.shift_byte[3'd7 - s.bit_count[2:0]];
                s.phase    = PH_TX_HI;
            end
            PH_TX_HI: begin
                s.drv_sck   = 1'b1;
                s.bit_count = s.bit_count + 4'd1;
                s.phase     = (s.bit_count >= BITS_PER_BYTE) ? PH_TX_ENDLO : PH_TX_LO;
            end
            PH_TX_ENDLO: begin
                s.drv_sck = 1'b0;
                s.phase   = PH_TX_REL;
            end
            PH_TX_REL: begin
                s.drv_pull = 1'b0;
                s.phase    = PH_TX_ACKHI;
            end
            PH_TX_ACKHI: begin
                s.drv_sck = 1'b1;
                s.phase   = PH_TX_ACKSMP;
            end
            PH_TX_ACKSMP: begin
                s.drv_sck = 1'b0;
                s.crc     = crc8_feed(s.crc, s.shift_byte);
                if (i_data_level) begin
                    done    = 1'b1;
                    st      = ST_NO_ACK;
                    s.phase = PH_IDLE;
                end else if (s.is_reset_op) begin
                    done    = 1'b1;
                    st      = ST_OK;
                    s.phase = PH_IDLE;
                end else begin
                    s.poll_count = '0;
                    s.wait_count = '0;
                    s.phase      = PH_POLL;
                end
            end
            PH_POLL: begin
                s.drv_sck  = 1'b0;
                s.drv_pull = 1'b0;
                if (s.wait_count != 16'd0) begin
                    s.wait_count = s.wait_count - 16'd1;
                end
                // Check DATA once the interval count has run out
                if (s.wait_count == 16'd0) begin
                    if (s.poll_count >= i_cfg.max_polls) begin
                        done    = 1'b1;
                        st      = ST_TIMEOUT;
                        s.phase = PH_IDLE;
                    end else if (!i_data_level) begin
                        s.bit_count  = '0;
                        s.poll_count = '0;
                        s.shift_byte = '0;
                        s.phase      = PH_RX_HI;
                    end else begin
                        s.poll_count = s.poll_count + 8'd1;
                        s.wait_count = i_cfg.poll_interval;
                    end
                end
            end
            PH_RX_HI: begin
                s.drv_sck  = 1'b1;
                s.drv_pull = 1'b0;
                s.phase    = PH_RX_LO;
            end
            PH_RX_LO: begin
                s.shift_byte = {s.shift_byte[6:0], i_data_level};
                s.drv_sck    = 1'b0;
                s.bit_count  = s.bit_count + 4'd1;
                if (s.bit_count < BITS_PER_BYTE) begin
                    s.phase = PH_RX_HI;
                end else if (s.poll_count < ACKED_BYTES) begin
                    s.crc   = crc8_feed(s.crc, s.shift_byte);
                    s.value = {s.value[7:0], s.shift_byte};
                    s.phase = PH_RXA_PULL;
                end else begin
                    s.phase = PH_RXN_HI;
                end
            end
            PH_RXA_PULL: begin
                s.drv_pull = 1'b1;
                s.phase    = PH_RXA_HI;
            end
            PH_RXA_HI: begin
                s.drv_sck = 1'b1;
                s.phase   = PH_RXA_LO;
            end
            PH_RXA_LO: begin
                s.drv_sck = 1'b0;
                s.phase   = PH_RXA_REL;
            end
            PH_RXA_REL: begin
                s.drv_pull   = 1'b0;
                s.poll_count = s.poll_count + 8'd1;
                s.bit_count  = '0;
                s.shift_byte = '0;
                s.phase      = PH_RX_HI;
            end
            PH_RXN_HI: begin
                s.drv_sck  = 1'b1;
                s.drv_pull = 1'b0;
                s.phase    = PH_RXN_LO;
            end
            PH_RXN_LO: begin
                s.drv_sck = 1'b0;
                done      = 1'b1;
                st        = (mirror8(s.shift_byte) == s.crc) ? ST_OK : ST_CRC_ERR;
                val       = s.value;
                s.phase   = PH_IDLE;
            end
            default: begin
                s.phase = PH_IDLE;
            end
        endcase
    end

    // Drive the tick result from the updated state
    assign o_state                 = s;
    assign o_result.sck_level      = s.drv_sck;
    assign o_result.data_pull_low  = s.drv_pull;
    assign o_result.busy_res       = (s.phase != PH_IDLE);
    assign o_result.done_res       = done;
    assign o_result.measured_value = val;
    assign o_result.status         = st;

endmodule

>>> hdl/two_wire_sensor_measure_master.sv
`timescale 1ns / 1ps
// A result appears in the output register in the cycle after its tick is taken.
// Throughput: one tick per clock; a new tick is taken while the previous result
// is still held, as long as the output register is free or being emptied that cycle.
// Reset (synchronous, active low) idles the sequencer, releases DATA with SCK low
// and loads the register defaults: status nibble 0, poll interval 100, max polls 62.

module two_wire_sensor_measure_master
    import tws_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tws_in_if.sink    i_in,
    tws_cfg_if.sink   i_cfg,
    tws_out_if.source o_out
);

    t_state  r_state;
    t_state  n_state;
    t_cfg    r_cfg;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    in_xfer;

    // Take a tick when the output register is empty or drains this cycle
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    tws_step u_step (
        .i_state        (r_state),
        .i_cfg          (r_cfg),
        .i_cmd          (i_in.cmd),
        .i_command_byte (i_in.command_byte),
        .i_data_level   (i_in.data_level),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.status_nibble <= STATUS_NIBBLE_RST;
            r_cfg.poll_interval <= POLL_INTERVAL_RST;
            r_cfg.max_polls     <= MAX_POLLS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_STATUS_NIBBLE: r_cfg.status_nibble <= i_cfg.data[3:0];
                REG_POLL_INTERVAL: r_cfg.poll_interval <= i_cfg.data;
                REG_MAX_POLLS:     r_cfg.max_polls     <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer state advances on each tick transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, default: '0};
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.sck_level      = r_result.sck_level;
    assign o_out.data_pull_low  = r_result.data_pull_low;
    assign o_out.busy_res       = r_result.busy_res;
    assign o_out.done_res       = r_result.done_res;
    assign o_out.measured_value = r_result.measured_value;
    assign o_out.status         = r_result.status;

    // A finishing tick never reports busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.done_res |-> !o_out.busy_res)
        else $error("done result reports busy");

    // Value and status stay zero on ticks that do not finish
    a_quiet_unless_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.done_res |-> o_out.status == ST_OK && o_out.measured_value == 16'd0)
        else $error("value or status set without done");

    // A plain tick while idle stays idle and finishes nothing
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && r_state.phase == PH_IDLE && i_in.cmd == CMD_TICK
        |=> o_out.valid && !o_out.busy_res && !o_out.done_res)
        else $error("plain idle tick changed sequencer");

    // Bit counter never passes the reset pulse count
    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bit_count <= RST_PULSES)
        else $error("bit counter out of range");

endmodule
